// ===== hw/rtl/hdst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdst_pkg: shared types and constants for the hall direction/speed tracker
// Holds register indexes, stream widths, the edge job record and the
// successor table lookup.
// ----------------------------------------------------------------------------
package hdst_pkg;

  // Parameter defaults
  localparam int PERIOD_WIDTH_DEF = 32;
  localparam int MISS_LIMIT_DEF   = 6;

  // Stream and register port widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;

  // Item kinds on the input stream
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_EDGE = 1'b1;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_FWD_TBL     = 3'd0;
  localparam logic [2:0] REG_REV_TBL     = 3'd1;
  localparam logic [2:0] REG_EDGES_PER   = 3'd2;
  localparam logic [2:0] REG_SPEED_SCALE = 3'd3;
  localparam logic [2:0] REG_ANGLE_SCALE = 3'd4;

  localparam logic [7:0] EDGES_PER_RESET = 8'd6;

  // Hall codes that never occur on a healthy sensor set
  localparam logic [2:0] HALL_ALL_LOW  = 3'd0;
  localparam logic [2:0] HALL_ALL_HIGH = 3'd7;

  // Configuration register set
  typedef struct packed {
    logic [23:0] fwd_tbl;
    logic [23:0] rev_tbl;
    logic [7:0]  edges_per;
    logic [31:0] speed_scale;
    logic [30:0] angle_scale;
  } hdst_cfg_t;

  // One classified hall edge, handed from front to back
  typedef struct packed {
    logic [2:0] code;
    logic       valid;
    logic       rev;
    logic [2:0] misses;
    logic       upd;
    logic       clr;
  } hdst_job_t;

  // Expected next code after idx, from a packed table of eight 3-bit entries
  function automatic logic [2:0] tbl_entry(input logic [23:0] tbl, input logic [2:0] idx);
    logic [4:0] pos;
    pos = {2'b00, idx} * 5'd3;
    return tbl[pos +: 3];
  endfunction

endpackage

// ===== hw/rtl/hall_direction_speed_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hall_direction_speed_tracker: hall sensor direction and speed tracker
// Tracks rotation direction from hall code sequences and estimates speed
// and angle step from timer ticks counted between hall edges.
//
//   port group  role    contents
//   in_*        slave   tuser: op; tdata: hall_bits
//   out_*       master  one item per hall edge, none per tick
//   cfg_*       APB     five registers at byte addresses 0,4,8,12,16
//
// A tick item is taken without entering the queue and gives no result.
// A hall edge is classified in its accept cycle. An edge that recomputes
// speed from a nonzero period is then loaded by the back end, runs 32
// radix-2 divider steps and is handed off; any other edge goes from load straight to hand-off.
// The two-entry job queue lets ticks and edges be taken while a division
// runs; in_tready drops only while the queue is full.
// Reset is synchronous and clears all tracking state and the registers.
// ----------------------------------------------------------------------------
module hall_direction_speed_tracker #(
  parameter int PERIOD_WIDTH = hdst_pkg::PERIOD_WIDTH_DEF,
  parameter int MISS_LIMIT   = hdst_pkg::MISS_LIMIT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [hdst_pkg::IN_TDATA_W-1:0]     in_tdata,   // [2:0] hall_bits
  input  logic                                in_tuser,   // [0] op
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [2:0] hall_code, [3] reverse_dir, [6:4] miss_count,
  // [38:7] speed_value, [70:39] angle_step
  output logic [hdst_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [hdst_pkg::OUT_TUSER_W-1:0]    out_tuser,  // [0] hall_valid, [1] speed_updated
  // configuration
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [hdst_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [hdst_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [hdst_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import hdst_pkg::*;

  localparam int JOB_W = $bits(hdst_job_t) + PERIOD_WIDTH;

  hdst_cfg_t cfg_r;
  logic      cfg_wr;
  logic [2:0] reg_idx;

  hdst_job_t               f_job, b_job;
  logic [PERIOD_WIDTH-1:0] f_period, b_period;
  logic                    push, pop, q_full, q_valid;
  logic [JOB_W-1:0]        q_rdata;

  logic [2:0]  o_code, o_misses;
  logic        o_code_ok, o_rev, o_upd;
  logic [31:0] o_speed, o_step;

  // Register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fwd_tbl     <= 24'd0;
      cfg_r.rev_tbl     <= 24'd0;
      cfg_r.edges_per   <= EDGES_PER_RESET;
      cfg_r.speed_scale <= 32'd0;
      cfg_r.angle_scale <= 31'd0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FWD_TBL:     cfg_r.fwd_tbl     <= cfg_pwdata[23:0];
        REG_REV_TBL:     cfg_r.rev_tbl     <= cfg_pwdata[23:0];
        REG_EDGES_PER:   cfg_r.edges_per   <= cfg_pwdata[7:0];
        REG_SPEED_SCALE: cfg_r.speed_scale <= cfg_pwdata;
        REG_ANGLE_SCALE: cfg_r.angle_scale <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FWD_TBL:     cfg_prdata = {8'd0, cfg_r.fwd_tbl};
      REG_REV_TBL:     cfg_prdata = {8'd0, cfg_r.rev_tbl};
      REG_EDGES_PER:   cfg_prdata = {24'd0, cfg_r.edges_per};
      REG_SPEED_SCALE: cfg_prdata = cfg_r.speed_scale;
      REG_ANGLE_SCALE: cfg_prdata = {1'b0, cfg_r.angle_scale};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  // Front end
  hdst_front #(
    .PERIOD_WIDTH (PERIOD_WIDTH),
    .MISS_LIMIT   (MISS_LIMIT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_hall    (in_tdata[2:0]),
    .push       (push),
    .job        (f_job),
    .job_period (f_period),
    .q_full     (q_full)
  );

  // Job queue
  hdst_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wdata     ({f_job, f_period}),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .rdata     (q_rdata)
  );

  assign b_job    = q_rdata[JOB_W-1:PERIOD_WIDTH];
  assign b_period = q_rdata[PERIOD_WIDTH-1:0];

  // Back end
  hdst_back #(
    .PERIOD_WIDTH (PERIOD_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_valid     (q_valid),
    .pop         (pop),
    .job         (b_job),
    .job_period  (b_period),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_code    (o_code),
    .out_code_ok (o_code_ok),
    .out_rev     (o_rev),
    .out_misses  (o_misses),
    .out_upd     (o_upd),
    .out_speed   (o_speed),
    .out_step    (o_step)
  );

  // Result packing
  assign out_tdata = {1'b0, o_step, o_speed, o_misses, o_rev, o_code};
  assign out_tuser = {o_upd, o_code_ok};

endmodule

// ===== hw/rtl/hdst_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdst_front: input side of the tracker
// Accepts tick and edge items, keeps the period counter and the sequence
// state, and pushes one classified job per hall edge into the queue.
// ----------------------------------------------------------------------------
module hdst_front #(
  parameter int PERIOD_WIDTH = hdst_pkg::PERIOD_WIDTH_DEF,
  parameter int MISS_LIMIT   = hdst_pkg::MISS_LIMIT_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  hdst_pkg::hdst_cfg_t     cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_op,
  input  logic [2:0]              in_hall,
  output logic                    push,
  output hdst_pkg::hdst_job_t     job,
  output logic [PERIOD_WIDTH-1:0] job_period,
  input  logic                    q_full
);
  import hdst_pkg::*;

  localparam logic [3:0] LIMIT = 4'(MISS_LIMIT);

  logic [PERIOD_WIDTH-1:0] period_r, period_nxt;
  logic [7:0]              edge_cnt_r, edge_cnt_nxt;
  logic [2:0]              prev_code_r;
  logic                    prev_valid_r;
  logic [2:0]              misses_r, misses_nxt;
  logic                    dir_r, dir_nxt;

  logic       accept;
  logic       code_ok;
  logic       fwd_hit, rev_hit;
  logic [3:0] miss_inc;
  logic       at_limit;
  logic [7:0] edge_inc;
  logic       upd;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (in_op == OP_EDGE);

  // Edge classification against the successor tables
  assign code_ok  = (in_hall != HALL_ALL_LOW) && (in_hall != HALL_ALL_HIGH);
  assign fwd_hit  = code_ok && prev_valid_r && (in_hall == tbl_entry(cfg.fwd_tbl, prev_code_r));
  assign rev_hit  = code_ok && prev_valid_r && (in_hall == tbl_entry(cfg.rev_tbl, prev_code_r));
  assign miss_inc = {1'b0, misses_r} + 4'd1;
  assign at_limit = !fwd_hit && !rev_hit && (miss_inc >= LIMIT);
  assign edge_inc = edge_cnt_r + 8'd1;
  assign upd      = (edge_inc >= cfg.edges_per);

  always_comb begin
    misses_nxt = misses_r;
    dir_nxt    = dir_r;
    if (fwd_hit) begin
      misses_nxt = 3'd0;
      dir_nxt    = 1'b0;
    end else if (rev_hit) begin
      misses_nxt = 3'd0;
      dir_nxt    = 1'b1;
    end else if (at_limit) begin
      misses_nxt = LIMIT[2:0];
      dir_nxt    = 1'b0;
    end else begin
      misses_nxt = miss_inc[2:0];
    end
  end

  // Period counter and edge counter
  always_comb begin
    period_nxt   = period_r;
    edge_cnt_nxt = edge_cnt_r;
    if (accept) begin
      if (in_op == OP_TICK) begin
        if (period_r != {PERIOD_WIDTH{1'b1}}) begin
          period_nxt = period_r + PERIOD_WIDTH'(1);
        end
      end else if (upd) begin
        period_nxt   = '0;
        edge_cnt_nxt = 8'd0;
      end else begin
        edge_cnt_nxt = edge_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r     <= '0;
      edge_cnt_r   <= 8'd0;
      prev_code_r  <= 3'd0;
      prev_valid_r <= 1'b0;
      misses_r     <= 3'd0;
      dir_r        <= 1'b0;
    end else begin
      period_r   <= period_nxt;
      edge_cnt_r <= edge_cnt_nxt;
      if (push) begin
        prev_code_r  <= in_hall;
        prev_valid_r <= code_ok;
        misses_r     <= misses_nxt;
        dir_r        <= dir_nxt;
      end
    end
  end

  // Job record for the back end
  always_comb begin
    job.code   = in_hall;
    job.valid  = code_ok;
    job.rev    = dir_nxt;
    job.misses = misses_nxt;
    job.upd    = upd;
    job.clr    = at_limit;
  end
  assign job_period = period_r;

endmodule

// ===== hw/rtl/hdst_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdst_queue: two-entry job queue
// Flop-based FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module hdst_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem_r [2];
  logic             wptr_r, rptr_r;
  logic [1:0]       count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rdata     = mem_r[rptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wptr_r <= !wptr_r;
      end
      if (do_pop) begin
        rptr_r <= !rptr_r;
      end
    end
  end

  // Storage needs no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/hdst_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdst_back: speed and angle step computation
// Pops edge jobs, runs a shared-divisor radix-2 divider for speed and
// angle step, keeps the held estimates and drives the result register.
// ----------------------------------------------------------------------------
module hdst_back #(
  parameter int PERIOD_WIDTH = hdst_pkg::PERIOD_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  hdst_pkg::hdst_cfg_t     cfg,
  input  logic                    q_valid,
  output logic                    pop,
  input  hdst_pkg::hdst_job_t     job,
  input  logic [PERIOD_WIDTH-1:0] job_period,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              out_code,
  output logic                    out_code_ok,
  output logic                    out_rev,
  output logic [2:0]              out_misses,
  output logic                    out_upd,
  output logic [31:0]             out_speed,
  output logic [31:0]             out_step
);
  import hdst_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  hdst_job_t               job_r;
  logic [31:0]             speed_r, speed_nxt;
  logic [31:0]             step_r, step_nxt;
  logic [31:0]             num_s_r, num_s_nxt;
  logic [31:0]             num_a_r, num_a_nxt;
  logic [PERIOD_WIDTH-1:0] rem_s_r, rem_s_nxt;
  logic [PERIOD_WIDTH-1:0] rem_a_r, rem_a_nxt;
  logic [PERIOD_WIDTH-1:0] div_r;
  logic [4:0]              bit_r;
  logic                    out_valid_r;
  logic                    load_out;

  logic [PERIOD_WIDTH:0] sh_s, sh_a, dv;
  logic                  ge_s, ge_a;
  logic [PERIOD_WIDTH:0] dif_s, dif_a;

  // One restoring division step on both numerators
  assign dv    = {1'b0, div_r};
  assign sh_s  = {rem_s_r, num_s_r[31]};
  assign sh_a  = {rem_a_r, num_a_r[31]};
  assign ge_s  = (sh_s >= dv);
  assign ge_a  = (sh_a >= dv);
  assign dif_s = sh_s - dv;
  assign dif_a = sh_a - dv;
  assign rem_s_nxt = ge_s ? dif_s[PERIOD_WIDTH-1:0] : sh_s[PERIOD_WIDTH-1:0];
  assign rem_a_nxt = ge_a ? dif_a[PERIOD_WIDTH-1:0] : sh_a[PERIOD_WIDTH-1:0];
  assign num_s_nxt = {num_s_r[30:0], ge_s};
  assign num_a_nxt = {num_a_r[30:0], ge_a};

  assign pop      = (state_r == ST_IDLE) && q_valid;
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    speed_nxt = speed_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (job.clr) begin
            speed_nxt = 32'd0;
            step_nxt  = 32'd0;
          end
          if (job.upd && (job_period != '0)) begin
            state_nxt = ST_DIV;
          end else begin
            if (job.upd) begin
              speed_nxt = 32'd0;
              step_nxt  = 32'd0;
            end
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        if (bit_r == 5'd31) begin
          speed_nxt = num_s_nxt;
          step_nxt  = job_r.rev ? (32'd0 - num_a_nxt) : num_a_nxt;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      speed_r     <= 32'd0;
      step_r      <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      speed_r <= speed_nxt;
      step_r  <= step_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Divider datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      job_r   <= job;
      div_r   <= job_period;
      num_s_r <= cfg.speed_scale;
      num_a_r <= {1'b0, cfg.angle_scale};
      rem_s_r <= '0;
      rem_a_r <= '0;
      bit_r   <= 5'd0;
    end else if (state_r == ST_DIV) begin
      num_s_r <= num_s_nxt;
      num_a_r <= num_a_nxt;
      rem_s_r <= rem_s_nxt;
      rem_a_r <= rem_a_nxt;
      bit_r   <= bit_r + 5'd1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_code    <= job_r.code;
      out_code_ok <= job_r.valid;
      out_rev     <= job_r.rev;
      out_misses  <= job_r.misses;
      out_upd     <= job_r.upd;
      out_speed   <= speed_r;
      out_step    <= step_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/hdst_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdst_checker: port-level checks for the hall tracker
// Watches the result stream and checks direction, miss and clearing rules.
// ----------------------------------------------------------------------------
module hdst_checker #(
  parameter int MISS_LIMIT = hdst_pkg::MISS_LIMIT_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [hdst_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [hdst_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import hdst_pkg::*;

  localparam logic [2:0] LIMIT = 3'(MISS_LIMIT);

  logic [2:0] miss_cnt;
  logic       rev_dir;
  logic       upd;

  assign miss_cnt = out_tdata[6:4];
  assign rev_dir  = out_tdata[3];
  assign upd      = out_tuser[1];

  // No item is offered right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // Reaching the miss limit forces forward direction
  a_limit_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (miss_cnt == LIMIT) |-> !rev_dir)
    else $error("reverse direction reported at miss limit");

  // At the miss limit, held speed and step are cleared unless just recomputed
  a_limit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (miss_cnt == LIMIT) && !upd |->
      (out_tdata[38:7] == 32'd0) && (out_tdata[70:39] == 32'd0))
    else $error("speed not cleared at miss limit");

  // A stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind hall_direction_speed_tracker hdst_checker #(
  .MISS_LIMIT (MISS_LIMIT)
) u_hdst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/hall_tracker_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hall_tracker_checker: result checker for the hall direction/speed tracker
// Watches the input, result and register channels. Keeps its own copy of
// the register set and tracking state, works out the report each hall edge
// must produce, and compares each delivered report field by field with
// the oldest outstanding one.
// ----------------------------------------------------------------------------
module hall_tracker_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [hdst_pkg::IN_TDATA_W-1:0]     in_tdata,   // [2:0] hall_bits
  input  logic                                in_tuser,   // [0] op
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  // [2:0] hall_code, [3] reverse_dir, [6:4] miss_count,
  // [38:7] speed_value, [70:39] angle_step
  input  logic [hdst_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic [hdst_pkg::OUT_TUSER_W-1:0]    out_tuser,  // [0] hall_valid, [1] speed_updated
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [hdst_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [hdst_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  input  logic                                cfg_pready,
  output int                                  fail_count,
  output int                                  reports_due
);
  import hdst_pkg::*;

  localparam logic [31:0] TICKS_SAT = 32'hFFFF_FFFF >> (32 - PERIOD_WIDTH_DEF);
  localparam logic [2:0]  MISS_SAT  = 3'(MISS_LIMIT_DEF);
  localparam int          MAX_PRINT = 40;

  // One report as the block should deliver it for a hall edge
  typedef struct {
    logic [2:0]  code;
    logic        valid;
    logic        rev;
    logic [2:0]  misses;
    logic        upd;
    logic [31:0] speed;
    logic [31:0] step;
  } edge_report_t;

  edge_report_t edge_reports[$];
  edge_report_t want, got;
  int           errs = 0;

  // Shadow registers and tracking state
  hdst_cfg_t   regs;
  logic [31:0] ticks_acc;
  logic [7:0]  edge_cnt;
  logic [2:0]  last_code;
  logic        last_valid;
  logic [2:0]  miss_run;
  logic        reverse;
  logic [31:0] speed_now;
  logic [31:0] step_now;

  assign fail_count = errs;

  task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    errs++;
    if (errs <= MAX_PRINT)
      $display("%0t ns: %s mismatch, expected 0x%0h got 0x%0h", $time, what, exp_v, got_v);
  endtask

  // Classify one hall edge and update direction, misses and speed
  function automatic edge_report_t track_edge(input logic [2:0] code);
    edge_report_t r;
    logic [2:0]   fwd_next;
    logic [2:0]   rev_next;
    logic         ok;
    logic [31:0]  mag;
    fwd_next = regs.fwd_tbl[3*last_code +: 3];
    rev_next = regs.rev_tbl[3*last_code +: 3];
    ok = (code != HALL_ALL_LOW) && (code != HALL_ALL_HIGH);

    if (ok && last_valid && code == fwd_next) begin
      reverse  = 1'b0;
      miss_run = 3'd0;
    end else if (ok && last_valid && code == rev_next) begin
      reverse  = 1'b1;
      miss_run = 3'd0;
    end else begin
      // out of sequence, or invalid on either side
      miss_run = (miss_run >= MISS_SAT) ? MISS_SAT : miss_run + 3'd1;
      if (miss_run == MISS_SAT) begin
        reverse   = 1'b0;
        speed_now = '0;
        step_now  = '0;
      end
    end
    last_code  = code;
    last_valid = ok;

    // speed recompute every edges_per edges
    edge_cnt = edge_cnt + 8'd1;
    r.upd = 1'b0;
    if (edge_cnt >= regs.edges_per) begin
      r.upd    = 1'b1;
      edge_cnt = '0;
      if (ticks_acc == 0) begin
        speed_now = '0;
        step_now  = '0;
      end else begin
        mag       = {1'b0, regs.angle_scale} / ticks_acc;
        speed_now = regs.speed_scale / ticks_acc;
        step_now  = reverse ? 32'd0 - mag : mag;
      end
      ticks_acc = '0;
    end

    r.code   = code;
    r.valid  = ok;
    r.rev    = reverse;
    r.misses = miss_run;
    r.speed  = speed_now;
    r.step   = step_now;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      regs           = '0;
      regs.edges_per = EDGES_PER_RESET;
      ticks_acc      = '0;
      edge_cnt       = '0;
      last_code      = '0;
      last_valid     = 1'b0;
      miss_run       = '0;
      reverse        = 1'b0;
      speed_now      = '0;
      step_now       = '0;
      edge_reports.delete();
      reports_due <= 0;
    end else begin
      // delivered report against the oldest outstanding one
      if (out_tvalid && out_tready) begin
        got.code   = out_tdata[2:0];
        got.rev    = out_tdata[3];
        got.misses = out_tdata[6:4];
        got.speed  = out_tdata[38:7];
        got.step   = out_tdata[70:39];
        got.valid  = out_tuser[0];
        got.upd    = out_tuser[1];
        if (edge_reports.size() == 0) begin
          note_mismatch("unexpected result", 32'd0, {29'd0, got.code});
        end else begin
          want = edge_reports.pop_front();
          if (got.code !== want.code)
            note_mismatch("hall_code", 32'(want.code), 32'(got.code));
          if (got.valid !== want.valid)
            note_mismatch("hall_valid", 32'(want.valid), 32'(got.valid));
          if (got.rev !== want.rev)
            note_mismatch("reverse_dir", 32'(want.rev), 32'(got.rev));
          if (got.misses !== want.misses)
            note_mismatch("miss_count", 32'(want.misses), 32'(got.misses));
          if (got.upd !== want.upd)
            note_mismatch("speed_updated", 32'(want.upd), 32'(got.upd));
          if (got.speed !== want.speed)   note_mismatch("speed_value", want.speed, got.speed);
          if (got.step !== want.step)     note_mismatch("angle_step", want.step, got.step);
        end
      end

      // register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_FWD_TBL:     regs.fwd_tbl     = cfg_pwdata[23:0];
          REG_REV_TBL:     regs.rev_tbl     = cfg_pwdata[23:0];
          REG_EDGES_PER:   regs.edges_per   = cfg_pwdata[7:0];
          REG_SPEED_SCALE: regs.speed_scale = cfg_pwdata[31:0];
          REG_ANGLE_SCALE: regs.angle_scale = cfg_pwdata[30:0];
          default: ;
        endcase
      end

      // accepted input item
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_TICK) begin
          if (ticks_acc != TICKS_SAT) ticks_acc = ticks_acc + 32'd1;
        end else begin
          edge_reports.push_back(track_edge(in_tdata[2:0]));
        end
      end
      reports_due <= edge_reports.size();
    end
  end

endmodule

// ===== tb/hall_direction_speed_tracker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hall_direction_speed_tracker_tb: testbench for the hall tracker
// Drives tick and hall edge items with random gaps and random result-side
// stalls, programs the registers between phases, and leaves checking to
// hall_tracker_checker. Starts with hand-picked edge sequences, then runs
// rotor-like hall sequences with noise under several register settings.
// ----------------------------------------------------------------------------
module hall_direction_speed_tracker_tb;
  import hdst_pkg::*;

  localparam int         HALF_PERIOD    = 6;
  localparam int         CYCLE_LIMIT    = 400000;
  localparam int         LONG_HOLD      = 300;
  localparam int         SETTLE_CYCLES  = 40;
  localparam int         PHASES         = 6;
  localparam int         PHASE_ITEMS    = 130;
  localparam logic [2:0] REG_UNUSED     = 3'd5;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [2:0] hall_bits
  logic                   in_tuser;   // [0] op
  logic                   out_tvalid;
  logic                   out_tready;
  // [2:0] hall_code, [3] reverse_dir, [6:4] miss_count,
  // [38:7] speed_value, [70:39] angle_step
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;  // [0] hall_valid, [1] speed_updated
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_ADDR_W-1:0]  cfg_paddr;
  logic [CFG_DATA_W-1:0]  cfg_pwdata;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  int         fail_count;
  int         reports_due;
  int         cycle_count = 0;
  bit         rx_long_hold = 1'b0;
  bit         no_idle = 1'b0;

  // Rotor model: one electrical turn as six hall codes
  logic [2:0] rot_seq [6];
  int         rot_pos;
  int         rot_dir;

  hall_direction_speed_tracker uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  hall_tracker_checker tracker_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (fail_count),
    .reports_due (reports_due)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("hall_direction_speed_tracker_tb: errors");
      $finish;
    end
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  // Result side: random stalls, one long hold on request
  initial begin : result_sink
    int pause;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_long_hold) begin
        pause = LONG_HOLD;
        rx_long_hold = 1'b0;
      end else begin
        pause = draw_gap();
      end
      if (pause != 0) begin
        out_tready <= 1'b0;
        repeat (pause) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Offer one item after a random gap; returns once it is taken
  task automatic send_item(input logic op, input logic [2:0] bits);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_TDATA_W'(bits);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop sending, wait for every report, then let the block go idle
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic new_rotor();
    int         j;
    logic [2:0] t;
    for (int i = 0; i < 6; i++) rot_seq[i] = 3'(i + 1);
    for (int i = 5; i > 0; i--) begin
      j          = $urandom_range(0, i);
      t          = rot_seq[i];
      rot_seq[i] = rot_seq[j];
      rot_seq[j] = t;
    end
    rot_pos = 0;
    rot_dir = 1;
  endtask

  // Successor tables from the rotor order; entries for codes 0 and 7 random
  task automatic write_tables(input bit mirror);
    logic [23:0] fwd;
    logic [23:0] rev;
    fwd = 24'($urandom);
    rev = 24'($urandom);
    for (int i = 0; i < 6; i++) begin
      fwd[3*rot_seq[i] +: 3]         = rot_seq[(i + 1) % 6];
      rev[3*rot_seq[(i + 1) % 6] +: 3] = rot_seq[i];
    end
    if (mirror) rev = fwd;
    apb_write(REG_FWD_TBL, 32'(fwd));
    apb_write(REG_REV_TBL, 32'(rev));
  endtask

  initial begin : stimulus
    int         sent;
    int         burst;
    int         pick;
    logic [2:0] code;
    logic [7:0] edges;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = OP_TICK;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // registers still at reset: zero tables, first edge misses
    send_item(OP_EDGE, 3'd3);
    send_item(OP_TICK, 3'd5);
    send_item(OP_EDGE, 3'd2);
    send_item(OP_TICK, 3'd2);
    send_item(OP_EDGE, 3'd6);
    settle();

    // update on every edge, largest scales
    new_rotor();
    write_tables(1'b0);
    apb_write(REG_EDGES_PER, 32'd1);
    apb_write(REG_SPEED_SCALE, 32'hFFFF_FFFF);
    apb_write(REG_ANGLE_SCALE, 32'h7FFF_FFFF);
    apb_write(REG_UNUSED, 32'hFFFF_FFFF);   // no register here

    send_item(OP_EDGE, rot_seq[0]);
    send_item(OP_TICK, 3'd7);
    send_item(OP_EDGE, rot_seq[1]);         // forward, period one
    send_item(OP_TICK, 3'd0);
    send_item(OP_TICK, 3'd1);
    send_item(OP_EDGE, rot_seq[2]);         // forward
    send_item(OP_EDGE, rot_seq[1]);         // reverse with zero period
    send_item(OP_TICK, 3'd4);
    send_item(OP_EDGE, rot_seq[0]);         // reverse, negative step
    send_item(OP_EDGE, HALL_ALL_LOW);       // invalid code
    send_item(OP_EDGE, rot_seq[1]);         // previous invalid
    send_item(OP_EDGE, HALL_ALL_HIGH);
    send_item(OP_EDGE, HALL_ALL_HIGH);
    send_item(OP_EDGE, HALL_ALL_LOW);
    send_item(OP_EDGE, HALL_ALL_HIGH);      // miss limit reached
    send_item(OP_TICK, 3'd6);
    send_item(OP_EDGE, rot_seq[2]);         // stays saturated
    send_item(OP_EDGE, rot_seq[3]);         // back in sequence
    send_item(OP_EDGE, rot_seq[3]);         // repeated code
    send_item(OP_TICK, 3'd3);
    send_item(OP_EDGE, rot_seq[4]);
    settle();

    // random phases, each under its own register setting
    for (int phase = 0; phase < PHASES; phase++) begin
      new_rotor();
      write_tables(phase == 4);
      case (phase)
        0: begin
          edges = 8'd0;
          apb_write(REG_SPEED_SCALE, 32'hFFFF_FFFF);
          apb_write(REG_ANGLE_SCALE, 32'h7FFF_FFFF);
        end
        1: begin
          edges = 8'd255;
          apb_write(REG_SPEED_SCALE, $urandom());
          apb_write(REG_ANGLE_SCALE, $urandom_range(0, 32'h7FFF_FFFF));
        end
        2: begin
          edges = 8'd1;
          apb_write(REG_SPEED_SCALE, 32'd0);
          apb_write(REG_ANGLE_SCALE, 32'd0);
        end
        5: begin
          edges = 8'($urandom_range(2, 8));
          apb_write(REG_SPEED_SCALE, 32'hFFFF_FFFF);
          apb_write(REG_ANGLE_SCALE, 32'd0);
        end
        default: begin
          edges = (phase == 4) ? EDGES_PER_RESET : 8'($urandom_range(1, 12));
          apb_write(REG_SPEED_SCALE, $urandom());
          apb_write(REG_ANGLE_SCALE, $urandom_range(0, 32'h7FFF_FFFF));
        end
      endcase
      apb_write(REG_EDGES_PER, 32'(edges));
      rx_long_hold = (phase == 2);
      no_idle      = (phase == 3);

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // ticks between edges, now and then a slow stretch
        burst = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
        repeat (burst) begin
          send_item(OP_TICK, 3'($urandom_range(0, 7)));
          sent++;
        end
        pick = $urandom_range(0, 99);
        if (pick < 8) rot_dir = -rot_dir;
        if (pick < 78)
          rot_pos = (rot_pos + rot_dir + 6) % 6;
        else if (pick < 86)
          rot_pos = (rot_pos + 2 * rot_dir + 6) % 6;   // skipped code
        code = (pick >= 86 && pick < 94) ? 3'($urandom_range(0, 7)) : rot_seq[rot_pos];
        send_item(OP_EDGE, code);
        sent++;
      end
      no_idle = 1'b0;
      settle();
    end

    if (fail_count == 0 && reports_due == 0)
      $display("hall_direction_speed_tracker_tb: clean");
    else
      $display("hall_direction_speed_tracker_tb: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/hdst_pkg.sv
hw/rtl/hdst_front.sv
hw/rtl/hdst_queue.sv
hw/rtl/hdst_back.sv
hw/rtl/hall_direction_speed_tracker.sv
hw/rtl/hdst_checker.sv
tb/hall_tracker_checker.sv
tb/hall_direction_speed_tracker_tb.sv
